// File: src/dupp_pkg.sv
// Shared types and constants for the drive/user prefix parser.
package dupp_pkg;

    localparam int MAX_PREFIX_LEN     = 255;
    localparam int ALPHA_COLON_WINDOW = 4;
    localparam int LEN_LIMIT          = (MAX_PREFIX_LEN > 255) ? 255 : MAX_PREFIX_LEN;
    localparam int QUEUE_DEPTH        = 2;

    localparam int VOL_W   = 5;
    localparam int UA_W    = 8;
    localparam int CH_W    = 8;
    localparam int LEN_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W  = 12;

    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CASE_BIT = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_UA       = 1'b1;

    localparam logic [VOL_W-1:0] VOLUME_COUNT_RST = 5'd16;
    localparam logic [UA_W-1:0]  MAX_UA_RST       = 8'd15;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_ALPHA  = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef struct packed {
        logic             start;
        logic             last;
        logic             is_letter;
        logic             is_digit;
        logic             is_colon;
        logic [VOL_W-1:0] letter_val;
        logic [3:0]       digit_val;
        logic [VOL_W-1:0] cur_vol;
        logic [UA_W-1:0]  cur_ua;
    } tok_t;

    typedef struct packed {
        logic             matched;
        logic [LEN_W-1:0] prefix_len;
        logic [VOL_W-1:0] vol_id;
        logic [UA_W-1:0]  ua_id;
    } res_t;

endpackage

// File: src/drive_user_prefix_parser.sv
// Top level of the drive/user prefix parser.
// Takes one filespec character per cycle, unless out_ready back-pressure stalls it, and gives
// at most one result per argument: whether a drive/user prefix matched, its length, and the
// resulting volume and user area. A result passes the classify register, the token queue and
// the state machine with its result register. The state update for one character, a
// multiply by ten and compare against the user-area maximum, sets the cycle. Write
// registers only while no argument is in flight.
module drive_user_prefix_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dupp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dupp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_req,
    input  logic [dupp_pkg::CH_W-1:0]         ch,
    input  logic                              last,
    input  logic [dupp_pkg::VOL_W-1:0]        cur_vol,
    input  logic [dupp_pkg::UA_W-1:0]         cur_ua,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              matched,
    output logic [dupp_pkg::LEN_W-1:0]        prefix_len,
    output logic [dupp_pkg::VOL_W-1:0]        vol_id,
    output logic [dupp_pkg::UA_W-1:0]         ua_id
);
    import dupp_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready;
    tok_t f_tok, q_tok;
    res_t res;

    dupp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_req (start_req),
        .ch        (ch),
        .last      (last),
        .cur_vol   (cur_vol),
        .cur_ua    (cur_ua),
        .tok_valid (f_valid),
        .tok_ready (f_ready),
        .tok       (f_tok)
    );

    dupp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tok   (f_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    dupp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign matched    = res.matched;
    assign prefix_len = res.prefix_len;
    assign vol_id     = res.vol_id;
    assign ua_id      = res.ua_id;

endmodule

// File: src/dupp_front.sv
// Front end: accepts characters, classifies them and hands tokens to the queue.
module dupp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_req,
    input  logic [dupp_pkg::CH_W-1:0]     ch,
    input  logic                          last,
    input  logic [dupp_pkg::VOL_W-1:0]    cur_vol,
    input  logic [dupp_pkg::UA_W-1:0]     cur_ua,
    output logic                          tok_valid,
    input  logic                          tok_ready,
    output dupp_pkg::tok_t                tok
);
    import dupp_pkg::*;

    logic stage_valid_reg, stage_valid_next;
    tok_t stage_reg, stage_next;
    logic accept;
    logic [CH_W-1:0] folded;

    assign in_ready  = !stage_valid_reg || tok_ready;
    assign accept    = in_valid && in_ready;
    assign tok_valid = stage_valid_reg;
    assign tok       = stage_reg;
    assign folded    = (ch | CASE_BIT) - CH_LC_A;

    always_comb
    begin
        stage_next            = stage_reg;
        stage_next.start      = start_req;
        stage_next.last       = last;
        stage_next.is_letter  = (ch >= CH_UC_A && ch <= CH_UC_Z) ||
                                (ch >= CH_LC_A && ch <= CH_LC_Z);
        stage_next.is_digit   = (ch >= CH_ZERO && ch <= CH_NINE);
        stage_next.is_colon   = (ch == CH_COLON);
        stage_next.letter_val = folded[VOL_W-1:0];
        stage_next.digit_val  = ch[3:0];
        stage_next.cur_vol    = cur_vol;
        stage_next.cur_ua     = cur_ua;
        if (!accept)
        begin
            stage_next = stage_reg;
        end
    end

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (tok_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

// File: src/dupp_queue.sv
// Short token queue between the front end and the back end.
module dupp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dupp_pkg::tok_t push_tok,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dupp_pkg::tok_t pop_tok
);
    import dupp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    tok_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

// File: src/dupp_back.sv
// Back end: prefix state machine, configuration registers and result register.
module dupp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dupp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dupp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              tok_valid,
    output logic                              tok_ready,
    input  dupp_pkg::tok_t                    tok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dupp_pkg::res_t                    res
);
    import dupp_pkg::*;

    localparam logic [LEN_W:0] LIMIT_W  = (LEN_W+1)'(LEN_LIMIT);
    localparam logic [LEN_W-1:0] WINDOW = LEN_W'(ALPHA_COLON_WINDOW);

    logic [VOL_W-1:0] vol_count_reg;
    logic [UA_W-1:0]  max_ua_reg;

    phase_t           phase_reg, phase_next;
    logic [UA_W-1:0]  digit_reg, digit_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [VOL_W-1:0] letter_reg, letter_next;
    logic [VOL_W-1:0] svol_reg, svol_next;
    logic [UA_W-1:0]  sua_reg, sua_next;

    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic             pop, fire;
    res_t             r;
    logic [PROD_W-1:0] acc;
    logic [PROD_W-1:0] nv;
    logic [LEN_W:0]    cnt_plus2;

    assign tok_ready = !out_valid_reg || out_ready;
    assign pop       = tok_valid && tok_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign acc       = tok.start ? '0 : {{(PROD_W-UA_W){1'b0}}, digit_reg};
    assign nv        = (acc << 3) + (acc << 1) + {{(PROD_W-4){1'b0}}, tok.digit_val};
    assign cnt_plus2 = {1'b0, count_reg} + (LEN_W+1)'(2);

    always_comb
    begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        count_next  = count_reg;
        letter_next = letter_reg;
        svol_next   = svol_reg;
        sua_next    = sua_reg;
        fire        = 1'b0;
        r.matched    = 1'b0;
        r.prefix_len = '0;
        r.vol_id     = tok.start ? tok.cur_vol : svol_reg;
        r.ua_id      = tok.start ? tok.cur_ua : sua_reg;
        if (tok.start)
        begin
            svol_next   = tok.cur_vol;
            sua_next    = tok.cur_ua;
            digit_next  = '0;
            count_next  = '0;
            letter_next = '0;
            phase_next  = PH_IDLE;
            if (tok.is_letter)
            begin
                letter_next = tok.letter_val;
                if (tok.letter_val >= vol_count_reg)
                    fire = 1'b1;
                else
                begin
                    phase_next = PH_ALPHA;
                    count_next = LEN_W'(1);
                end
            end
            else if (tok.is_digit)
            begin
                if (nv > {{(PROD_W-UA_W){1'b0}}, max_ua_reg} || LEN_LIMIT < 2)
                    fire = 1'b1;
                else
                begin
                    digit_next = nv[UA_W-1:0];
                    phase_next = PH_DIGITS;
                    count_next = LEN_W'(1);
                end
            end
            else
                fire = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_ALPHA:
                begin
                    if (tok.is_colon)
                    begin
                        fire         = 1'b1;
                        r.matched    = 1'b1;
                        r.prefix_len = count_reg + 1'b1;
                        r.vol_id     = letter_reg;
                        r.ua_id      = (count_reg > LEN_W'(1)) ? digit_reg : sua_reg;
                    end
                    else if (count_reg >= WINDOW || !tok.is_digit)
                        fire = 1'b1;
                    else if (nv > {{(PROD_W-UA_W){1'b0}}, max_ua_reg})
                        fire = 1'b1;
                    else
                    begin
                        digit_next = nv[UA_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (tok.is_colon)
                    begin
                        fire         = 1'b1;
                        r.matched    = 1'b1;
                        r.prefix_len = count_reg + 1'b1;
                        r.vol_id     = svol_reg;
                        r.ua_id      = digit_reg;
                    end
                    else if (!tok.is_digit || cnt_plus2 > LIMIT_W)
                        fire = 1'b1;
                    else if (nv > {{(PROD_W-UA_W){1'b0}}, max_ua_reg})
                        fire = 1'b1;
                    else
                    begin
                        digit_next = nv[UA_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    fire = 1'b0;
                end
            endcase
        end
        if (!fire && tok.last && phase_next != PH_IDLE)
            fire = 1'b1;
        if (fire)
            phase_next = PH_IDLE;
    end

    always_comb
    begin
        res_next = res_reg;
        if (pop && fire)
        begin
            res_next       = r;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_count_reg <= VOLUME_COUNT_RST;
            max_ua_reg    <= MAX_UA_RST;
            phase_reg     <= PH_IDLE;
            digit_reg     <= '0;
            count_reg     <= '0;
            letter_reg    <= '0;
            svol_reg      <= '0;
            sua_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VOLUME_COUNT: vol_count_reg <= cfg_wdata[VOL_W-1:0];
                    REG_MAX_UA:       max_ua_reg    <= cfg_wdata[UA_W-1:0];
                    default:          max_ua_reg    <= max_ua_reg;
                endcase
            end
            if (pop)
            begin
                phase_reg  <= phase_next;
                digit_reg  <= digit_next;
                count_reg  <= count_next;
                letter_reg <= letter_next;
                svol_reg   <= svol_next;
                sua_reg    <= sua_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
